@@ src/spike_filter_edge_trigger_top_assert.svh @@
// Assertion macros used by the checker of the spike filter block.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message string.
`ifndef SPIKE_FILTER_EDGE_TRIGGER_TOP_ASSERT_SVH
`define SPIKE_FILTER_EDGE_TRIGGER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SFET_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SFET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sfet_pkg.sv @@
package sfet_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;
    localparam int TUSER_OUT_W = 3;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int MODE_W      = 2;

    localparam logic [SAMPLE_W-1:0] THRESH_RST = 12'd2048;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FILTER_EN   = 2'd0,
        CFG_SPIKE_LIMIT = 2'd1,
        CFG_THRESH      = 2'd2,
        CFG_TRIG_MODE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        TRIG_RISE = 2'd0,
        TRIG_FALL = 2'd1,
        TRIG_OFF  = 2'd2
    } t_trig_mode;

    typedef enum logic [1:0] {
        FILL_EMPTY  = 2'd0,
        FILL_CENTER = 2'd1,
        FILL_FULL   = 2'd2
    } t_fill;

    typedef struct packed {
        logic                filter_en;
        logic [SAMPLE_W-1:0] spike_limit;
        logic [SAMPLE_W-1:0] thresh;
        logic [MODE_W-1:0]   trig_mode;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] last_out;
        logic [SAMPLE_W-1:0] center;
        t_fill               fill;
        logic                armed;
    } t_state;

    typedef struct packed {
        logic                out_valid;
        logic [SAMPLE_W-1:0] out_sample;
        logic                spike_fixed;
        logic                triggered;
    } t_result;

endpackage

@@ src/sfet_cfg_regs.sv @@
module sfet_cfg_regs
    import sfet_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_ADDR_W-1:0] i_addr,
    input  logic [CFG_DATA_W-1:0] i_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_en   <= 1'b0;
            r_cfg.spike_limit <= '0;
            r_cfg.thresh      <= THRESH_RST;
            r_cfg.trig_mode   <= TRIG_RISE;
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_addr))
                CFG_FILTER_EN:   r_cfg.filter_en   <= i_wdata[0];
                CFG_SPIKE_LIMIT: r_cfg.spike_limit <= i_wdata[SAMPLE_W-1:0];
                CFG_THRESH:      r_cfg.thresh      <= i_wdata[SAMPLE_W-1:0];
                CFG_TRIG_MODE:   r_cfg.trig_mode   <= i_wdata[MODE_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/sfet_step.sv @@
module sfet_step
    import sfet_pkg::*;
(
    input  t_cfg                i_cfg,
    input  t_state              i_state,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_restart,
    output t_state              o_state,
    output t_result             o_result
);

    logic [SAMPLE_W-1:0] diff_left;
    logic [SAMPLE_W-1:0] diff_right;
    logic [SAMPLE_W:0]   nbr_sum;
    logic                is_spike;
    logic [SAMPLE_W-1:0] filt;
    logic                edge_hit;

    // Distances of the centre from the filtered left and the new right sample.
    assign diff_left  = (i_state.last_out > i_state.center) ?
                        i_state.last_out - i_state.center :
                        i_state.center - i_state.last_out;
    assign diff_right = (i_sample > i_state.center) ?
                        i_sample - i_state.center :
                        i_state.center - i_sample;
    assign nbr_sum    = {1'b0, i_state.last_out} + {1'b0, i_sample};
    assign is_spike   = i_cfg.filter_en && (diff_left > i_cfg.spike_limit)
                        && (diff_right > i_cfg.spike_limit);
    assign filt       = is_spike ? nbr_sum[SAMPLE_W:1] : i_state.center;

    always_comb begin
        unique case (i_cfg.trig_mode)
            TRIG_RISE: edge_hit = (i_state.last_out < i_cfg.thresh)
                                  && (filt > i_cfg.thresh);
            TRIG_FALL: edge_hit = (i_state.last_out > i_cfg.thresh)
                                  && (filt < i_cfg.thresh);
            default:   edge_hit = 1'b0;
        endcase
    end

    always_comb begin
        o_state         = i_state;
        o_state.center  = i_sample;
        o_result        = '0;
        if (i_restart || i_state.fill == FILL_EMPTY) begin
            // start a capture; drop any pending centre
            o_state.fill = FILL_CENTER;
            if (i_restart) begin
                o_state.armed = 1'b1;
            end
        end else if (i_state.fill == FILL_CENTER) begin
            // first word of a capture passes untouched
            o_result.out_valid  = 1'b1;
            o_result.out_sample = i_state.center;
            o_state.last_out    = i_state.center;
            o_state.fill        = FILL_FULL;
        end else begin
            o_result.out_valid   = 1'b1;
            o_result.out_sample  = filt;
            o_result.spike_fixed = is_spike;
            o_result.triggered   = i_state.armed && edge_hit;
            if (i_state.armed && edge_hit) begin
                o_state.armed = 1'b0;
            end
            o_state.last_out = filt;
            o_state.fill     = FILL_FULL;
        end
    end

endmodule

@@ src/spike_filter_edge_trigger_top.sv @@
// Spike filter with one-shot edge trigger.
//
// Slave stream: one converter sample per word in s_axis_tdata, s_axis_tuser
// set on the first word of a capture. Master stream: one result word per
// accepted input word, carrying the filtered sample of the previous position
// and three flags (valid, spike fixed, triggered) in m_axis_tuser.
// Configuration: plain write port; registers are written only while idle,
// a rule for the user that the block itself does not enforce.
//
// An accepted word is stepped from the input register into the result
// register, which drives the master side. One word per cycle while the
// receiver takes words: the filter state feeds back within the single
// step stage, so consecutive words never wait for each other.
// Reset (synchronous, active low) clears both stages, empties the capture,
// arms the trigger and loads the register defaults (level 2048).
// When the receiver stalls, the result register holds its word, the input
// register fills behind it and then s_axis_tready drops until the word
// is taken.
module spike_filter_edge_trigger_top
    import sfet_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // slave stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [11:0] sample, [15:12] zero
    input  logic                   s_axis_tuser,  // [0] restart
    // master stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // [11:0] out_sample, [15:12] zero
    output logic [TUSER_OUT_W-1:0] m_axis_tuser   // [0] out_valid, [1] spike_fixed,
                                                  // [2] triggered
);

    t_cfg                cfg;
    t_state              n_state;
    t_result             n_result;
    logic                out_adv;
    logic                step_adv;
    logic                in_take;

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_in_restart;
    t_state              r_state;
    logic                r_out_valid;
    t_result             r_out;

    sfet_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    sfet_step u_step (
        .i_cfg     (cfg),
        .i_state   (r_state),
        .i_sample  (r_in_sample),
        .i_restart (r_in_restart),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // Result register frees when empty or when its word is taken.
    assign out_adv       = !r_out_valid || m_axis_tready;
    assign step_adv      = r_in_valid && out_adv;
    assign s_axis_tready = !r_in_valid || out_adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register: hold the word until the step stage consumes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample  <= s_axis_tdata[SAMPLE_W-1:0];
            r_in_restart <= s_axis_tuser;
        end
    end

    // Filter state advances exactly once per consumed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_out <= '0;
            r_state.center   <= '0;
            r_state.fill     <= FILL_EMPTY;
            r_state.armed    <= 1'b1;
        end else if (step_adv) begin
            r_state <= n_state;
        end
    end

    // Result register: load on step, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_adv) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_OUT_W-SAMPLE_W){1'b0}}, r_out.out_sample};
    assign m_axis_tuser  = {r_out.triggered, r_out.spike_fixed, r_out.out_valid};

endmodule

@@ src/sfet_checker.sv @@
`include "spike_filter_edge_trigger_top_assert.svh"

module sfet_checker
    import sfet_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [TDATA_OUT_W-1:0] m_axis_tdata,
    input  logic [TUSER_OUT_W-1:0] m_axis_tuser
);

    // A word without a finished sample carries no sample and no flags.
    `SFET_ASSERT_IMP(a_empty_word_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata == '0 && m_axis_tuser[2:1] == 2'b00,
        "result word without a sample carries data")

    // Spike and trigger flags only accompany a finished sample.
    `SFET_ASSERT_IMP(a_flags_need_sample, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser[1] || m_axis_tuser[2]),
        m_axis_tuser[0],
        "flag set on a word without a sample")

    // Padding above the sample stays clear.
    `SFET_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n,
        m_axis_tvalid,
        m_axis_tdata[TDATA_OUT_W-1:SAMPLE_W] == '0,
        "padding bits of result word set")

    // Hold a stalled result word.
    `SFET_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled result word changed")

endmodule

bind spike_filter_edge_trigger_top sfet_checker u_sfet_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ verif/spike_filter_edge_trigger_top_tb.sv @@
// Self-checking bench for the spike filter with one-shot edge trigger.
//
// A directed table runs first: configuration writes and sample words, some
// rows with their result typed in, the rest checked against the in-bench
// filter model. Random phases follow, each with its own register setting:
// a random walk that hovers on the trigger level, spikes just beyond the
// spike limit, plain noise and the odd restart.
module spike_filter_edge_trigger_top_tb;
    import sfet_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 4;    // result passes the input and result registers after acceptance
    localparam int STALL_CYCLES    = 60;   // long receiver hold-off
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int WATCHDOG_TIME   = 2_000_000;

    // mode 3 has no name in the package; the block treats it as trigger off
    localparam logic [MODE_W-1:0] TRIG_MODE_RSVD = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata;   // [11:0] sample, [15:12] zero
    logic                   s_axis_tuser;   // [0] restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;   // [11:0] out_sample, [15:12] zero
    logic [TUSER_OUT_W-1:0] m_axis_tuser;   // [0] out_valid, [1] spike_fixed, [2] triggered

    spike_filter_edge_trigger_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Hard limit on the run.
    initial begin
        #WATCHDOG_TIME;
        $display("** spike_filter_edge_trigger_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Filter model: register shadow and capture state
    // ------------------------------------------------------------------
    t_cfg         cfg_now   = '{filter_en: 1'b0, spike_limit: '0,
                                thresh: THRESH_RST, trig_mode: TRIG_RISE};
    logic [11:0]  prev_out  = '0;     // last emitted, already filtered
    logic [11:0]  held_mid  = '0;     // centre waiting for its right neighbour
    t_fill        held_fill = FILL_EMPTY;
    logic         trig_armed = 1'b1;

    t_result      due_words[$];       // filtered words still to come out
    int           mismatches = 0;

    // Word being offered: typed expectation travels with it where the table has one.
    bit           word_typed = 1'b0;
    t_result      word_want  = '0;

    // Flow control of the two sides.
    bit           steady_flow   = 1'b0;
    bit           stall_request = 1'b0;

    function automatic logic [11:0] dist12(logic [11:0] a, logic [11:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Advance the filter by one sample and return the word it emits.
    function automatic t_result filter_step(logic [11:0] smp, logic rs);
        t_result     r;
        logic [11:0] mid;
        logic [12:0] pair_sum;
        logic        hit;
        r = '0;
        if (rs || held_fill == FILL_EMPTY) begin
            // new capture; the old centre is dropped, only a restart rearms
            if (rs)
                trig_armed = 1'b1;
            held_mid  = smp;
            held_fill = FILL_CENTER;
        end else begin
            mid = held_mid;
            r.out_valid = 1'b1;
            // the first word of a capture has no left neighbour
            if (held_fill == FILL_FULL) begin
                if (cfg_now.filter_en && dist12(prev_out, mid) > cfg_now.spike_limit &&
                    dist12(smp, mid) > cfg_now.spike_limit) begin
                    pair_sum      = {1'b0, prev_out} + {1'b0, smp};
                    mid           = pair_sum[12:1];
                    r.spike_fixed = 1'b1;
                end
                case (cfg_now.trig_mode)
                    TRIG_RISE: hit = prev_out < cfg_now.thresh && mid > cfg_now.thresh;
                    TRIG_FALL: hit = prev_out > cfg_now.thresh && mid < cfg_now.thresh;
                    default:   hit = 1'b0;
                endcase
                if (trig_armed && hit) begin
                    r.triggered = 1'b1;
                    trig_armed  = 1'b0;
                end
            end
            r.out_sample = mid;
            prev_out     = mid;
            held_mid     = smp;
            held_fill    = FILL_FULL;
        end
        return r;
    endfunction

    function automatic void check_field(string what, logic [11:0] want, logic [11:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Edge monitor: shadow register writes, check outgoing words, then
    // predict incoming ones. Checking first keeps a stray word from
    // matching the one accepted at the same edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_FILTER_EN:   cfg_now.filter_en   = i_cfg_wdata[0];
                    CFG_SPIKE_LIMIT: cfg_now.spike_limit = i_cfg_wdata;
                    CFG_THRESH:      cfg_now.thresh      = i_cfg_wdata;
                    CFG_TRIG_MODE:   cfg_now.trig_mode   = i_cfg_wdata[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_valid   = m_axis_tuser[0];
                got.out_sample  = m_axis_tdata[SAMPLE_W-1:0];
                got.spike_fixed = m_axis_tuser[1];
                got.triggered   = m_axis_tuser[2];
                if (due_words.size() == 0) begin
                    $display("%0t: word with nothing expected, expected none, got %0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = due_words.pop_front();
                    check_field("out_valid",   12'(want.out_valid),   12'(got.out_valid));
                    check_field("out_sample",  want.out_sample,       got.out_sample);
                    check_field("spike_fixed", 12'(want.spike_fixed), 12'(got.spike_fixed));
                    check_field("triggered",   12'(want.triggered),   12'(got.triggered));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                // keep the model in step even where the table gives the answer
                want = filter_step(s_axis_tdata[SAMPLE_W-1:0], s_axis_tuser);
                if (word_typed)
                    want = word_want;
                due_words.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, a quiet phase and one long hold-off
    // ------------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                // hold off long enough for both stages to fill and stall the input
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge i_clk);
                stall_request = 1'b0;
            end else begin
                m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    // Offer one word, idling first at random; valid stays high on return.
    task automatic send_word(logic [11:0] smp, logic rs, bit typed, t_result want);
        if (!steady_flow && $urandom_range(0, 99) < 10) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 1)) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_IN_W'(smp);
        s_axis_tuser  <= rs;
        word_typed    <= typed;
        word_want     <= want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every expected word has come out.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        bit          is_write;
        t_cfg_idx    reg_idx;
        logic [11:0] value;      // register value, or the sample
        logic        restart;
        bit          typed;
        t_result     want;
    } t_plan_row;

    t_plan_row plan[$];

    function automatic t_plan_row reg_row(t_cfg_idx idx, int value);
        t_plan_row r;
        r          = '{reg_idx: CFG_FILTER_EN, default: '0};
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.value    = 12'(value);
        return r;
    endfunction

    function automatic t_plan_row model_row(int smp, bit rs);
        t_plan_row r;
        r         = '{reg_idx: CFG_FILTER_EN, default: '0};
        r.reg_idx = CFG_FILTER_EN;
        r.value   = 12'(smp);
        r.restart = rs;
        return r;
    endfunction

    function automatic t_plan_row known_row(int smp, bit rs, bit v, int o, bit f, bit t);
        t_plan_row r;
        r                  = model_row(smp, rs);
        r.typed            = 1'b1;
        r.want.out_valid   = v;
        r.want.out_sample  = 12'(o);
        r.want.spike_fixed = f;
        r.want.triggered   = t;
        return r;
    endfunction

    function automatic logic [11:0] clip12(int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'hFFF;
        return 12'(v);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int                lim;
        int                lvl;
        int                wave;
        int                pick;
        int                off;
        bit                filt;
        bit                first_rs;
        logic [MODE_W-1:0] mode_pick;
        logic [11:0]       smp;
        logic              rs;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;

        // Defaults after reset: filter off, level 2048, rising edge.
        // A word with no capture open starts one and emits an empty word.
        plan.push_back(known_row(0,    0, 0, 0,    0, 0));
        plan.push_back(known_row(4095, 0, 1, 0,    0, 0));   // first word, never triggers
        plan.push_back(known_row(0,    0, 1, 4095, 0, 1));   // full-scale rising crossing
        plan.push_back(known_row(4095, 0, 1, 0,    0, 0));   // one-shot: no second fire
        plan.push_back(known_row(4095, 1, 0, 0,    0, 0));   // restart drops pending centre
        plan.push_back(known_row(2048, 0, 1, 4095, 0, 0));
        plan.push_back(known_row(0,    0, 1, 2048, 0, 0));
        plan.push_back(known_row(2049, 0, 1, 0,    0, 0));   // from the level: not below it
        plan.push_back(known_row(2048, 0, 1, 2049, 0, 1));   // one count above fires
        plan.push_back(model_row(0, 0));
        // Filter on with zero limit, low level, falling edge.
        plan.push_back(reg_row(CFG_FILTER_EN, 1));
        plan.push_back(reg_row(CFG_SPIKE_LIMIT, 0));
        plan.push_back(reg_row(CFG_THRESH, 100));
        plan.push_back(reg_row(CFG_TRIG_MODE, TRIG_FALL));
        plan.push_back(known_row(0,    1, 0, 0,    0, 0));
        plan.push_back(known_row(4095, 0, 1, 0,    0, 0));   // first word passes unfiltered
        plan.push_back(known_row(0,    0, 1, 0,    1, 0));   // full-scale spike, average zero
        plan.push_back(known_row(4095, 1, 0, 0,    0, 0));
        plan.push_back(known_row(4095, 0, 1, 4095, 0, 0));
        plan.push_back(model_row(0, 0));
        plan.push_back(known_row(4095, 0, 1, 4095, 1, 0));   // dip spike, average full scale
        plan.push_back(model_row(50, 0));
        plan.push_back(model_row(40, 0));
        plan.push_back(model_row(40, 0));
        plan.push_back(model_row(4095, 0));
        // Widest limit, level zero, reserved mode: nothing filters, nothing fires.
        plan.push_back(reg_row(CFG_SPIKE_LIMIT, 4095));
        plan.push_back(reg_row(CFG_THRESH, 0));
        plan.push_back(reg_row(CFG_TRIG_MODE, TRIG_MODE_RSVD));
        plan.push_back(model_row(0, 1));
        plan.push_back(model_row(4095, 0));
        plan.push_back(model_row(0, 0));
        plan.push_back(model_row(4095, 0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_write) begin
                drain();
                write_reg(plan[k].reg_idx, plan[k].value);
            end else begin
                send_word(plan[k].value, plan[k].restart, plan[k].typed, plan[k].want);
            end
        end

        // Random phases; each sets every register while the block is idle.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            lim  = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 4095 : int'($urandom_range(1, 400));
            lvl  = (ph == 5) ? 0 : (ph == 6) ? 4095 : int'($urandom_range(200, 3900));
            filt = !(ph == 3 || ph == 7);
            if (ph == 0)
                mode_pick = TRIG_RISE;
            else if (ph == 1)
                mode_pick = TRIG_FALL;
            else
                mode_pick = MODE_W'($urandom_range(TRIG_RISE, TRIG_MODE_RSVD));
            write_reg(CFG_FILTER_EN,   CFG_DATA_W'(filt));
            write_reg(CFG_SPIKE_LIMIT, CFG_DATA_W'(lim));
            write_reg(CFG_THRESH,      CFG_DATA_W'(lvl));
            write_reg(CFG_TRIG_MODE,   CFG_DATA_W'(mode_pick));

            steady_flow = (ph == 2);
            if (ph == 4)
                stall_request = 1'b1;

            wave     = lvl;
            first_rs = 1'($urandom_range(0, 1));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                // hover on the level so that edges keep crossing it
                if (pick < 12)
                    wave = lvl + int'($urandom_range(0, 8)) - 4;
                else if (pick < 70)
                    wave = wave + int'($urandom_range(0, 64)) - 32;
                wave = int'(clip12(wave));
                if (pick >= 70 && pick < 85) begin
                    // spike just beyond the limit on either side
                    off = lim + 1 + int'($urandom_range(0, 64));
                    smp = clip12($urandom_range(0, 1) ? wave + off : wave - off);
                end else if (pick >= 85) begin
                    smp = 12'($urandom_range(0, 4095));
                end else begin
                    smp = 12'(wave);
                end
                rs = (n == 0) ? first_rs : ($urandom_range(0, 99) < 3);
                send_word(smp, rs, 1'b0, '0);
            end
        end

        drain();
        if (due_words.size() != 0) begin
            $display("%0t: words left over, expected 0, got %0d", $time, due_words.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("** spike_filter_edge_trigger_top: PASSED **");
        else
            $display("** spike_filter_edge_trigger_top: FAILED **");
        $finish;
    end

endmodule
